// ----- rtl/dmavg_pkg.sv -----
// shared types, constants and helpers for the dead-band moving average block
`default_nettype none

package dmavg_pkg;

  localparam int unsigned DATA_W           = 16;
  localparam int unsigned CFG_IDX_W        = 4;
  localparam int unsigned DEF_WINDOW_DEPTH = 16;
  localparam int unsigned PIPE_STAGES      = 7;
  localparam int unsigned RECIP_SHIFT      = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BAND_HIGH = 4'd0,
    CFG_BAND_LOW  = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_x;
    logic signed [DATA_W-1:0] sample_y;
    logic signed [DATA_W-1:0] sample_z;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] mean_x;
    logic signed [DATA_W-1:0] mean_y;
    logic signed [DATA_W-1:0] mean_z;
  } out_word_t;

  // per-stage load strobes from the shared pipeline control
  typedef struct packed {
    logic acc;
    logic upd;
    logic mag_ld;
    logic mul_ld;
    logic corr_ld;
    logic fix_ld;
  } lane_ctrl_t;

  // zero a value lying strictly between the two bounds
  function automatic logic signed [DATA_W-1:0] dead_band(
    input logic signed [DATA_W-1:0] v,
    input logic signed [DATA_W-1:0] lo,
    input logic signed [DATA_W-1:0] hi
  );
    return ((v < hi) && (v > lo)) ? '0 : v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dmavg_div.sv -----
// pipelined divide of a magnitude by the window depth, reciprocal multiply plus one correction
`default_nettype none

module dmavg_div #(
  parameter int unsigned DIVISOR = dmavg_pkg::DEF_WINDOW_DEPTH,
  parameter int unsigned MAG_W   = 20
) (
  input  wire logic                      clk,
  input  wire dmavg_pkg::lane_ctrl_t     ctrl,
  input  wire logic [MAG_W-1:0]          mag,
  input  wire logic                      neg,
  output logic [dmavg_pkg::DATA_W-1:0]   quo,
  output logic                           quo_neg
);

  localparam int unsigned PROD_W = MAG_W + 32;
  localparam int unsigned DIV_W  = $clog2(DIVISOR + 1);
  localparam logic [31:0] RECIP  = 32'((64'd1 << dmavg_pkg::RECIP_SHIFT) / DIVISOR);
  localparam logic [DIV_W-1:0] DIV_K = DIV_W'(DIVISOR);

  logic [PROD_W-1:0]      prod_r;
  logic [MAG_W-1:0]       mag_a_r;
  logic                   neg_a_r;
  logic [MAG_W-1:0]       q0_r;
  logic [MAG_W+DIV_W-1:0] qd_r;
  logic [MAG_W-1:0]       mag_b_r;
  logic                   neg_b_r;
  logic [MAG_W-1:0]       q_r;
  logic                   neg_c_r;

  logic [MAG_W-1:0]       q0_w;
  logic [MAG_W-1:0]       rem_w;

  // estimate is floor or floor minus one
  assign q0_w  = prod_r[dmavg_pkg::RECIP_SHIFT +: MAG_W];
  assign rem_w = mag_b_r - qd_r[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.mul_ld) begin
      prod_r  <= PROD_W'(mag) * PROD_W'(RECIP);
      mag_a_r <= mag;
      neg_a_r <= neg;
    end
    if (ctrl.corr_ld) begin
      q0_r    <= q0_w;
      qd_r    <= (MAG_W + DIV_W)'(q0_w) * (MAG_W + DIV_W)'(DIV_K);
      mag_b_r <= mag_a_r;
      neg_b_r <= neg_a_r;
    end
    if (ctrl.fix_ld) begin
      q_r     <= (rem_w >= MAG_W'(DIVISOR)) ? q0_r + 1'b1 : q0_r;
      neg_c_r <= neg_b_r;
    end
  end

  assign quo     = q_r[dmavg_pkg::DATA_W-1:0];
  assign quo_neg = neg_c_r;

endmodule

`default_nettype wire

// ----- rtl/dmavg_lane.sv -----
// one axis lane: input dead band, history ring, running total and dead-banded mean
`default_nettype none

module dmavg_lane #(
  parameter int unsigned WINDOW_DEPTH = dmavg_pkg::DEF_WINDOW_DEPTH,
  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dmavg_pkg::lane_ctrl_t               ctrl,
  input  wire logic [SLOT_W-1:0]                   slot,
  input  wire logic signed [dmavg_pkg::DATA_W-1:0] sample,
  input  wire logic signed [dmavg_pkg::DATA_W-1:0] band_high,
  input  wire logic signed [dmavg_pkg::DATA_W-1:0] band_low,
  output logic signed [dmavg_pkg::DATA_W-1:0]      mean
);

  localparam int unsigned DW    = dmavg_pkg::DATA_W;
  localparam int unsigned SUM_W = DW + $clog2(WINDOW_DEPTH);

  logic [DW-1:0]           ring_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] ring_ok_r;

  logic signed [DW-1:0]    v1_r;
  logic [SLOT_W-1:0]       slot1_r;
  logic [DW-1:0]           rd1_r;
  logic                    rd_ok1_r;

  // two most recent writes, to cover reads that raced them
  logic                    w1_ok_r, w2_ok_r;
  logic [SLOT_W-1:0]       w1_slot_r, w2_slot_r;
  logic signed [DW-1:0]    w1_v_r, w2_v_r;

  logic signed [SUM_W-1:0] total_r;
  logic signed [SUM_W-1:0] total_nxt;
  logic signed [DW-1:0]    old_w;

  logic [SUM_W-1:0]        mag_r;
  logic                    neg_r;

  logic [DW-1:0]           quo;
  logic                    quo_neg;
  logic signed [DW:0]      mean_ext;
  logic signed [DW-1:0]    mean_raw;

  always_ff @(posedge clk) begin
    if (ctrl.upd) ring_mem[slot1_r] <= v1_r;
    if (ctrl.acc) rd1_r <= ring_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_ok_r <= '0;
      w1_ok_r   <= 1'b0;
      w2_ok_r   <= 1'b0;
      total_r   <= '0;
    end else if (ctrl.upd) begin
      ring_ok_r[slot1_r] <= 1'b1;
      w1_ok_r            <= 1'b1;
      w2_ok_r            <= w1_ok_r;
      total_r            <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.acc) begin
      v1_r     <= dmavg_pkg::dead_band(sample, band_low, band_high);
      slot1_r  <= slot;
      rd_ok1_r <= ring_ok_r[slot];
    end
    if (ctrl.upd) begin
      w1_slot_r <= slot1_r;
      w1_v_r    <= v1_r;
      w2_slot_r <= w1_slot_r;
      w2_v_r    <= w1_v_r;
    end
    if (ctrl.mag_ld) begin
      neg_r <= total_r[SUM_W-1];
      mag_r <= total_r[SUM_W-1] ? $unsigned(-total_r) : $unsigned(total_r);
    end
  end

  // oldest sample leaving the window
  always_comb begin
    if (w1_ok_r && (w1_slot_r == slot1_r)) begin
      old_w = w1_v_r;
    end else if (w2_ok_r && (w2_slot_r == slot1_r)) begin
      old_w = w2_v_r;
    end else if (rd_ok1_r) begin
      old_w = $signed(rd1_r);
    end else begin
      old_w = '0;
    end
  end

  assign total_nxt = total_r + SUM_W'(v1_r) - SUM_W'(old_w);

  dmavg_div #(
    .DIVISOR (WINDOW_DEPTH),
    .MAG_W   (SUM_W)
  ) u_div (
    .clk     (clk),
    .ctrl    (ctrl),
    .mag     (mag_r),
    .neg     (neg_r),
    .quo     (quo),
    .quo_neg (quo_neg)
  );

  assign mean_ext = quo_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign mean_raw = mean_ext[DW-1:0];
  assign mean     = dmavg_pkg::dead_band(mean_raw, band_low, band_high);

endmodule

`default_nettype wire

// ----- rtl/deadband_moving_average_3axis.sv -----
// top level: three-axis dead-band moving average with shared pipeline control and output word
// a result is valid once its word has passed the acc, upd, mag, mul, corr and fix stages and the output register
// throughput: one word per cycle unless out_stall has filled the pipeline, set by the running total update in each lane
// reset: clears ring entries (per-entry valid bits), totals, write slot, band bounds and pipeline
// ring contents need no clearing pass; an entry never written reads as zero
`default_nettype none

module deadband_moving_average_3axis #(
  parameter int unsigned WINDOW_DEPTH = dmavg_pkg::DEF_WINDOW_DEPTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input word channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire dmavg_pkg::in_word_t                   in_data,
  // result word channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output dmavg_pkg::out_word_t                       out_data,
  // register write channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [dmavg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dmavg_pkg::DATA_W-1:0]          cfg_data
);

  localparam int unsigned NSTG   = dmavg_pkg::PIPE_STAGES;
  localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  // band bounds
  logic signed [dmavg_pkg::DATA_W-1:0] band_high_r;
  logic signed [dmavg_pkg::DATA_W-1:0] band_low_r;

  // pipeline occupancy and movement
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] leave;
  logic [NSTG-1:0] ld;
  logic            in_free;

  // ring write pointer shared by the lanes
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;

  dmavg_pkg::lane_ctrl_t lane_ctrl;
  dmavg_pkg::out_word_t  out_data_r;
  logic signed [dmavg_pkg::DATA_W-1:0] mean_x, mean_y, mean_z;

  // config writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_high_r <= '0;
      band_low_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dmavg_pkg::CFG_BAND_HIGH: band_high_r <= cfg_data;
        dmavg_pkg::CFG_BAND_LOW:  band_low_r  <= cfg_data;
        default: ;  // unknown index ignored
      endcase
    end
  end

  // bubble-collapsing flow: a stage moves when the next one is empty or moving
  always_comb begin
    leave[NSTG-1] = vld_r[NSTG-1] & ~out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      leave[i] = vld_r[i] & (~vld_r[i+1] | leave[i+1]);
    end
    in_free = ~vld_r[0] | leave[0];
    ld[0]   = in_valid & in_free;
    for (int i = 1; i < NSTG; i++) begin
      ld[i] = leave[i-1];
    end
    vld_nxt = ld | (vld_r & ~leave);
  end

  assign in_stall = ~in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // write slot wraps after the last ring entry
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else if (ld[0]) begin
      slot_r <= slot_nxt;
    end
  end

  // stage strobes handed to every lane
  assign lane_ctrl.acc     = ld[0];
  assign lane_ctrl.upd     = ld[1];
  assign lane_ctrl.mag_ld  = ld[2];
  assign lane_ctrl.mul_ld  = ld[3];
  assign lane_ctrl.corr_ld = ld[4];
  assign lane_ctrl.fix_ld  = ld[5];

  // one lane per axis
  dmavg_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .slot      (slot_r),
    .sample    (in_data.sample_x),
    .band_high (band_high_r),
    .band_low  (band_low_r),
    .mean      (mean_x)
  );

  dmavg_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .slot      (slot_r),
    .sample    (in_data.sample_y),
    .band_high (band_high_r),
    .band_low  (band_low_r),
    .mean      (mean_y)
  );

  dmavg_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .slot      (slot_r),
    .sample    (in_data.sample_z),
    .band_high (band_high_r),
    .band_low  (band_low_r),
    .mean      (mean_z)
  );

  // merge: the three lane means form one result word in the output register
  always_ff @(posedge clk) begin
    if (ld[NSTG-1]) begin
      out_data_r.mean_x <= mean_x;
      out_data_r.mean_y <= mean_y;
      out_data_r.mean_z <= mean_z;
    end
  end

  assign out_data  = out_data_r;
  assign out_valid = vld_r[NSTG-1];

`ifndef SYNTHESIS
  // pipeline is empty and open right after reset
  assert property (@(posedge clk) !rst_n |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

  // with no result waiting, nothing can hold back the input
  assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // write slot steps once per accepted word and wraps at the window depth
  assert property (@(posedge clk) disable iff (!rst_n)
    ld[0] |=> (slot_r == (($past(slot_r) == SLOT_LAST) ? '0 : $past(slot_r) + 1'b1)))
    else $error("write slot did not advance on accept");

  assert property (@(posedge clk) disable iff (!rst_n) !ld[0] |=> $stable(slot_r))
    else $error("write slot moved without an accepted word");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for the three-axis dead-band moving average: queued random and directed words, self-checking
`timescale 1ns / 100ps

module testbench;
  import dmavg_pkg::*;

  localparam int WINDOW         = DEF_WINDOW_DEPTH;
  localparam int SETTLE_CYCLES  = PIPE_STAGES + 3;
  localparam int LONG_HOLD      = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_WORDS    = 100;
  // register codes past the last real register, expected to be ignored
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_REG = CFG_BAND_LOW + 1;
  localparam logic [CFG_IDX_W-1:0] LAST_REG_CODE    = '1;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BAND_HIGH;
  logic [DATA_W-1:0]    cfg_data  = '0;

  deadband_moving_average_3axis #(.WINDOW_DEPTH(WINDOW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // sample words waiting to be sent, predicted mean words waiting to come back
  in_word_t  sample_queue[$];
  out_word_t mean_queue[$];

  // register writes waiting for the next idle point
  logic [CFG_IDX_W-1:0] reg_idx_q[$];
  logic [DATA_W-1:0]    reg_val_q[$];

  // predictor state: band bounds, window history, per-axis totals, next slot
  logic signed [DATA_W-1:0] band_hi = '0;
  logic signed [DATA_W-1:0] band_lo = '0;
  int window_hist [WINDOW][3];
  int axis_total [3];
  int next_slot;

  int  mismatch_count = 0;
  int  send_gap = 0, send_calm = 0;
  int  recv_gap = 0, recv_calm = 0, hold_left = 0;
  bit  long_hold_req = 1'b0;
  int  idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    foreach (window_hist[i, a]) window_hist[i][a] = 0;
    foreach (axis_total[a]) axis_total[a] = 0;
    next_slot = 0;
  end

  // zero anything strictly inside the open interval (band_lo, band_hi)
  function automatic int squash_band(input int v);
    return (v < int'(band_hi) && v > int'(band_lo)) ? 0 : v;
  endfunction

  // push one sample into the history and queue the resulting mean word
  function automatic void predict_means(input in_word_t w);
    int raw [3];
    int res [3];
    int v;
    out_word_t m;
    raw[0] = int'(w.sample_x);
    raw[1] = int'(w.sample_y);
    raw[2] = int'(w.sample_z);
    for (int a = 0; a < 3; a++) begin
      v = squash_band(raw[a]);
      axis_total[a] += v - window_hist[next_slot][a];
      window_hist[next_slot][a] = v;
      // int division truncates toward zero, same as the block
      res[a] = squash_band(axis_total[a] / WINDOW);
    end
    m.mean_x = DATA_W'(res[0]);
    m.mean_y = DATA_W'(res[1]);
    m.mean_z = DATA_W'(res[2]);
    mean_queue.push_back(m);
    next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
  endfunction

  function automatic void check_means(input out_word_t got);
    out_word_t want;
    logic signed [DATA_W-1:0] g [3];
    logic signed [DATA_W-1:0] e [3];
    string names [3];
    if (mean_queue.size() == 0) begin
      $error("mean word with nothing expected: x=%0d y=%0d z=%0d",
             got.mean_x, got.mean_y, got.mean_z);
      mismatch_count++;
      return;
    end
    want = mean_queue.pop_front();
    names = '{"mean_x", "mean_y", "mean_z"};
    g = '{got.mean_x, got.mean_y, got.mean_z};
    e = '{want.mean_x, want.mean_y, want.mean_z};
    for (int a = 0; a < 3; a++) begin
      if (g[a] !== e[a]) begin
        $error("%s mismatch: expected %0d, got %0d", names[a], e[a], g[a]);
        mismatch_count++;
      end
    end
  endfunction

  // idle length: mostly none or short, now and then long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // sender: holds a word until taken, predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        predict_means(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (sample_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_queue.pop_front();
          send_gap = pick_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks accepted mean words, stalls at random or on a long hold request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        check_means(out_data);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (long_hold_req) begin
        // long back-pressure so the pipe fills and stalls its input
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_word_t mk_word(input int x, input int y, input int z);
    in_word_t w;
    w.sample_x = DATA_W'(x);
    w.sample_y = DATA_W'(y);
    w.sample_z = DATA_W'(z);
    return w;
  endfunction

  // one axis value: near a band edge, small, full scale, or any 16-bit pattern
  function automatic int pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)
      return ($urandom_range(0, 1) ? int'(band_hi) : int'(band_lo)) +
             int'($urandom_range(0, 6)) - 3;
    if (r < 55) return int'($urandom_range(0, 600)) - 300;
    if (r < 70) return $urandom_range(0, 1) ? 32767 : -32768;
    return int'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_extreme();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return 32767;
    if (r == 1) return -32768;
    return int'(band_hi);
  endfunction

  task automatic queue_random_words(input int count);
    int n, x, y, z;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 49) == 0) begin
        // constant run long enough to fill the window, pushes totals to the limit
        x = pick_extreme();
        y = pick_extreme();
        z = pick_extreme();
        repeat (WINDOW + 2) sample_queue.push_back(mk_word(x, y, z));
        n += WINDOW + 2;
      end else begin
        sample_queue.push_back(mk_word(pick_axis(), pick_axis(), pick_axis()));
        n++;
      end
    end
  endtask

  // choose band bounds for one phase; modes 0..6 cover the edge settings, any other mode picks random bounds
  task automatic plan_band(input int mode);
    int hi, lo, m;
    case (mode)
      0: begin hi = 0; lo = 0; end
      1: begin m = $urandom_range(1, 300); hi = m; lo = -m; end
      2: begin hi = 32767; lo = -32768; end
      3: begin hi = -32768; lo = 32767; end
      4: begin hi = int'($urandom_range(0, 2000)) - 1000; lo = hi - 1; end
      5: begin lo = $urandom_range(0, 500); hi = lo + $urandom_range(2, 800); end
      6: begin lo = int'($urandom_range(0, 1000)) - 500; hi = lo + 2; end
      default: begin
        hi = int'($urandom_range(0, 65535));
        lo = int'($urandom_range(0, 65535));
      end
    endcase
    if ($urandom_range(0, 2) == 0) begin
      reg_idx_q.push_back(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, LAST_REG_CODE)));
      reg_val_q.push_back(DATA_W'($urandom_range(0, 65535)));
    end
    if ($urandom_range(0, 1)) begin
      reg_idx_q.push_back(CFG_BAND_HIGH);
      reg_val_q.push_back(DATA_W'(hi));
      reg_idx_q.push_back(CFG_BAND_LOW);
      reg_val_q.push_back(DATA_W'(lo));
    end else begin
      reg_idx_q.push_back(CFG_BAND_LOW);
      reg_val_q.push_back(DATA_W'(lo));
      reg_idx_q.push_back(CFG_BAND_HIGH);
      reg_val_q.push_back(DATA_W'(hi));
    end
  endtask

  // write the queued registers one handshake at a time, block is idle here
  task automatic apply_reg_writes();
    while (reg_idx_q.size() != 0) begin
      cfg_index <= reg_idx_q[0];
      cfg_data  <= reg_val_q[0];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (reg_idx_q[0] == CFG_BAND_HIGH)
        band_hi = reg_val_q[0];
      else if (reg_idx_q[0] == CFG_BAND_LOW)
        band_lo = reg_val_q[0];
      void'(reg_idx_q.pop_front());
      void'(reg_val_q.pop_front());
    end
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued word is sent and every mean word is back
  task automatic wait_idle();
    @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || mean_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // warm-up with reset bounds (empty band), negative truncation, full scale
    sample_queue.push_back(mk_word(-15, -16, -17));
    sample_queue.push_back(mk_word(32767, -32768, 0));
    sample_queue.push_back(mk_word(-32768, 32767, -1));
    sample_queue.push_back(mk_word(1, -1, 16));
    sample_queue.push_back(mk_word(-1, -1, -1));
    sample_queue.push_back(mk_word(0, 0, 0));
    sample_queue.push_back(mk_word(-32768, -32768, -32768));
    sample_queue.push_back(mk_word(32767, 32767, 32767));
    wait_idle();

    // symmetric band plus two ignored register codes
    reg_idx_q.push_back(CFG_BAND_HIGH);
    reg_val_q.push_back(DATA_W'(100));
    reg_idx_q.push_back(CFG_BAND_LOW);
    reg_val_q.push_back(DATA_W'(-100));
    reg_idx_q.push_back(FIRST_UNUSED_REG);
    reg_val_q.push_back(DATA_W'(-1));
    reg_idx_q.push_back(LAST_REG_CODE);
    reg_val_q.push_back(DATA_W'(5));
    apply_reg_writes();

    // values on, inside and just outside both edges
    sample_queue.push_back(mk_word(99, -99, 100));
    sample_queue.push_back(mk_word(-100, 101, -101));
    sample_queue.push_back(mk_word(0, 50, -50));
    sample_queue.push_back(mk_word(32767, -32768, 100));
    sample_queue.push_back(mk_word(1600, -1600, 1615));
    sample_queue.push_back(mk_word(-1615, 1584, -1601));
    sample_queue.push_back(mk_word(-32768, 32767, -100));
    sample_queue.push_back(mk_word(1700, -1700, 99));
    wait_idle();

    // random phases, each with its own band setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      plan_band((p < 8) ? p : $urandom_range(0, 8));
      apply_reg_writes();
      queue_random_words(PHASE_WORDS);
      if (p == 2 || $urandom_range(0, 3) == 0)
        long_hold_req = 1'b1;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
